@@ hw/rtl/ltg_pkg.sv @@
// ----------------------------------------------------------------------------
// ltg_pkg: shared types and constants of the gray 3D table interpolator
// Operation codes, fixed field widths and scaling constants.
// ----------------------------------------------------------------------------
package ltg_pkg;

    // operation codes of one request
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam int BYTE_W   = 8;
    localparam int ENTRY_W  = 16;
    // sum of the three Q2.14 colours of one entry
    localparam int SUM_W    = ENTRY_W + 2;
    localparam int FRAC_W   = 8;
    // one axis weight, 0..256
    localparam int WGT_W    = FRAC_W + 1;
    // product of two weights, 0..2^16
    localparam int W2_W     = 2 * FRAC_W + 1;
    // product of three weights, 0..2^24
    localparam int W3_W     = 3 * FRAC_W + 1;
    // signed sum times weight, and the corner total
    localparam int PROD_W   = 44;

    localparam logic [BYTE_W-1:0] BYTE_MAX   = 8'd255;
    localparam logic [WGT_W-1:0]  FRAC_ONE   = 9'd256;
    // 255 / 3: gray scale on the channel average
    localparam logic [6:0]        GRAY_SCALE = 7'd85;
    localparam int                GRAY_SHIFT = 38;
    // three times one in Q.38
    localparam logic signed [PROD_W-1:0] TOTAL_LIMIT = 44'sh0C000000000;

endpackage

@@ hw/rtl/ltg_ram.sv @@
// ----------------------------------------------------------------------------
// ltg_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ltg_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 35937
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // register read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/ltg_axis.sv @@
// ----------------------------------------------------------------------------
// ltg_axis: maps one channel byte onto a cube axis
// Two stages: byte times (side - 1), then quotient and remainder by 255.
// ----------------------------------------------------------------------------
module ltg_axis #(
    parameter int MAX_SIDE = 33
) (
    input  logic                                  clk,
    input  logic [$clog2(MAX_SIDE+1)-1:0]         side_m1,
    input  logic [ltg_pkg::BYTE_W-1:0]            pixel,
    output logic [$clog2(MAX_SIDE)-1:0]           lo_reg,
    output logic [$clog2(MAX_SIDE)-1:0]           hi_reg,
    output logic [ltg_pkg::FRAC_W-1:0]            frac_reg
);

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int CW = $clog2(MAX_SIDE);
    localparam int PW = ltg_pkg::BYTE_W + SW;

    logic [PW-1:0]   prod_reg;
    logic [PW+1:0]   inc;
    logic [PW+1:0]   quot;
    logic [CW-1:0]   base;
    logic [PW+7:0]   base_x;
    logic [PW+7:0]   rem;

    // scale the byte
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(pixel * side_m1);
    end

    // divide by 255: floor(x/255) = ((x+1) + ((x+1) >> 8)) >> 8
    always_comb
    begin
        inc    = (PW+2)'(prod_reg) + (PW+2)'(1);
        quot   = (inc + (inc >> 8)) >> 8;
        base   = quot[CW-1:0];
        base_x = (PW+8)'(base) * (PW+8)'(ltg_pkg::BYTE_MAX);
        rem    = (PW+8)'(prod_reg) - base_x;
    end

    // remainder below 255 is already the Q0.8 fraction; clamp the upper corner
    always_ff @(posedge clk)
    begin
        lo_reg   <= base;
        hi_reg   <= ((SW)'(base) == side_m1) ? base : base + CW'(1);
        frac_reg <= rem[ltg_pkg::FRAC_W-1:0];
    end

endmodule

@@ hw/rtl/ltg_reduce.sv @@
// ----------------------------------------------------------------------------
// ltg_reduce: weighted corner sum and gray conversion
// Multiply, two adder levels, then clamp and scale to one gray byte.
// ----------------------------------------------------------------------------
module ltg_reduce (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [ltg_pkg::SUM_W-1:0]       sum   [8],
    input  logic        [ltg_pkg::W3_W-1:0]        wgt   [8],
    output logic                                   result_valid,
    output logic        [ltg_pkg::BYTE_W-1:0]      gray_value
);

    localparam int PW = ltg_pkg::PROD_W;

    logic                 f_valid_reg, g_valid_reg, h_valid_reg, o_valid_reg;
    logic signed [PW-1:0] prod_reg  [8];
    logic signed [PW-1:0] pair_reg  [4];
    logic signed [PW-1:0] total_reg;
    logic        [46:0]   scaled;
    logic        [ltg_pkg::BYTE_W-1:0] gray_next;
    logic        [ltg_pkg::BYTE_W-1:0] gray_reg;

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= in_valid;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
            o_valid_reg <= h_valid_reg;
        end
    end

    // weight each corner, then reduce the tree
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 8; c++)
        begin
            prod_reg[c] <= PW'(sum[c] * $signed({1'b0, wgt[c]}));
        end
        for (int k = 0; k < 4; k++)
        begin
            pair_reg[k] <= prod_reg[2*k] + prod_reg[2*k+1];
        end
        total_reg <= (pair_reg[0] + pair_reg[1]) + (pair_reg[2] + pair_reg[3]);
        gray_reg  <= gray_next;
    end

    // clamp to [0,1] and scale by 255 / (3 * 2^38)
    always_comb
    begin
        scaled = 47'(total_reg[39:0]) * 47'(ltg_pkg::GRAY_SCALE);
        if (total_reg <= 0)
        begin
            gray_next = '0;
        end
        else if (total_reg >= ltg_pkg::TOTAL_LIMIT)
        begin
            gray_next = ltg_pkg::BYTE_MAX;
        end
        else
        begin
            gray_next = scaled[ltg_pkg::GRAY_SHIFT +: ltg_pkg::BYTE_W];
        end
    end

    assign result_valid = o_valid_reg;
    assign gray_value   = gray_reg;

endmodule

@@ hw/rtl/lut3d_trilinear_gray_core.sv @@
// ----------------------------------------------------------------------------
// lut3d_trilinear_gray_core: 3D colour table with trilinear gray output
// Loads table entries and reduces pixels to gray bytes in a pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a request is taken at a clock edge with start high;
//   busy stays low, so one request can enter every cycle. operation selects
//   a table load (entry_index, entry_red/green/blue) or a pixel
//   (pixel_red/green/blue).
//   Configuration channel: cfg_valid/cfg_ready write lut_side from cfg_data;
//   cfg_ready is always high. Write it only while no pixel is in flight.
//   Results: each pixel gives one gray_value with result_valid high for one
//   cycle. Loads give no result. Throughput is one request per cycle.
//   The 8 corners are read together from 8 copies of the table, each
//   written by every load; a load writes at the same stage where pixels
//   read, so order is kept.
//   Only the sum of the three colours of an entry is stored.
//   Reset clears the valid bits and sets lut_side to 33; table contents are
//   undefined until loaded. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module lut3d_trilinear_gray_core #(
    parameter int MAX_SIDE = 33
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               operation,
    input  logic        [15:0]                 entry_index,
    input  logic signed [15:0]                 entry_red,
    input  logic signed [15:0]                 entry_green,
    input  logic signed [15:0]                 entry_blue,
    input  logic        [7:0]                  pixel_red,
    input  logic        [7:0]                  pixel_green,
    input  logic        [7:0]                  pixel_blue,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic        [5:0]                  cfg_data,
    output logic                               result_valid,
    output logic        [7:0]                  gray_value
);

    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = CW + 2 * SW + 2;
    localparam int SUMW  = ltg_pkg::SUM_W;

    // configuration
    logic [5:0]      lut_side_reg;
    logic [SW-1:0]   side;
    logic [SW-1:0]   side_m1;
    logic [2*SW-1:0] side_sq;

    // request stages A..E
    logic a_pix_reg, b_pix_reg, c_pix_reg, d_pix_reg, e_pix_reg;
    logic a_load_reg, b_load_reg, c_load_reg, d_load_reg;
    logic [15:0]              a_idx_reg, b_idx_reg, c_idx_reg, d_idx_reg;
    logic signed [SUMW-1:0]   a_sum_reg, b_sum_reg, c_sum_reg, d_sum_reg;
    logic [7:0]               a_r_reg, a_g_reg, a_b_reg;

    logic [CW-1:0]            r_lo, r_hi, g_lo, g_hi, b_lo, b_hi;
    logic [7:0]               r_fr, g_fr, b_fr;

    logic [TW-1:0]            d_rt_reg [2];
    logic [TW-1:0]            d_gt_reg [2];
    logic [TW-1:0]            d_bt_reg [2];
    logic [ltg_pkg::W2_W-1:0] d_rg_reg [4];
    logic [ltg_pkg::WGT_W-1:0] d_bw_reg [2];
    logic [ltg_pkg::WGT_W-1:0] rw [2];
    logic [ltg_pkg::WGT_W-1:0] gw [2];
    logic [ltg_pkg::WGT_W-1:0] bw [2];

    logic [ltg_pkg::W3_W-1:0] e_w_reg [8];
    logic [AW-1:0]            raddr [8];
    logic [TW-1:0]            asum  [8];
    logic signed [SUMW-1:0]   rdata [8];
    logic                     we;

    // hold the side register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lut_side_reg <= 6'd33;
        end
        else if (cfg_valid && cfg_ready)
        begin
            lut_side_reg <= cfg_data;
        end
    end

    // clamp side to the cube
    always_comb
    begin
        if (lut_side_reg < 6'd2)
        begin
            side = SW'(2);
        end
        else if (32'(lut_side_reg) > MAX_SIDE)
        begin
            side = SW'(MAX_SIDE);
        end
        else
        begin
            side = SW'(lut_side_reg);
        end
        side_m1 = side - SW'(1);
        side_sq = (2*SW)'(side * side);
    end

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // advance request valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_pix_reg  <= 1'b0;
            b_pix_reg  <= 1'b0;
            c_pix_reg  <= 1'b0;
            d_pix_reg  <= 1'b0;
            e_pix_reg  <= 1'b0;
            a_load_reg <= 1'b0;
            b_load_reg <= 1'b0;
            c_load_reg <= 1'b0;
            d_load_reg <= 1'b0;
        end
        else
        begin
            a_pix_reg  <= start && !busy && (operation == ltg_pkg::OP_PIXEL);
            a_load_reg <= start && !busy && (operation == ltg_pkg::OP_LOAD)
                          && (32'(entry_index) < DEPTH);
            b_pix_reg  <= a_pix_reg;
            c_pix_reg  <= b_pix_reg;
            d_pix_reg  <= c_pix_reg;
            e_pix_reg  <= d_pix_reg;
            b_load_reg <= a_load_reg;
            c_load_reg <= b_load_reg;
            d_load_reg <= c_load_reg;
        end
    end

    // capture the request and carry load data to the write stage
    always_ff @(posedge clk)
    begin
        a_idx_reg <= entry_index;
        a_sum_reg <= SUMW'(entry_red) + SUMW'(entry_green) + SUMW'(entry_blue);
        a_r_reg   <= pixel_red;
        a_g_reg   <= pixel_green;
        a_b_reg   <= pixel_blue;
        b_idx_reg <= a_idx_reg;
        b_sum_reg <= a_sum_reg;
        c_idx_reg <= b_idx_reg;
        c_sum_reg <= b_sum_reg;
        d_idx_reg <= c_idx_reg;
        d_sum_reg <= c_sum_reg;
    end

    ltg_axis #(.MAX_SIDE(MAX_SIDE)) u_axis_r (
        .clk(clk), .side_m1(side_m1), .pixel(a_r_reg),
        .lo_reg(r_lo), .hi_reg(r_hi), .frac_reg(r_fr)
    );
    ltg_axis #(.MAX_SIDE(MAX_SIDE)) u_axis_g (
        .clk(clk), .side_m1(side_m1), .pixel(a_g_reg),
        .lo_reg(g_lo), .hi_reg(g_hi), .frac_reg(g_fr)
    );
    ltg_axis #(.MAX_SIDE(MAX_SIDE)) u_axis_b (
        .clk(clk), .side_m1(side_m1), .pixel(a_b_reg),
        .lo_reg(b_lo), .hi_reg(b_hi), .frac_reg(b_fr)
    );

    // axis weights
    always_comb
    begin
        rw[0] = ltg_pkg::FRAC_ONE - ltg_pkg::WGT_W'(r_fr);
        rw[1] = ltg_pkg::WGT_W'(r_fr);
        gw[0] = ltg_pkg::FRAC_ONE - ltg_pkg::WGT_W'(g_fr);
        gw[1] = ltg_pkg::WGT_W'(g_fr);
        bw[0] = ltg_pkg::FRAC_ONE - ltg_pkg::WGT_W'(b_fr);
        bw[1] = ltg_pkg::WGT_W'(b_fr);
    end

    // scale axis indices into address terms, pair the weights
    always_ff @(posedge clk)
    begin
        d_rt_reg[0] <= TW'(r_lo);
        d_rt_reg[1] <= TW'(r_hi);
        d_gt_reg[0] <= TW'(g_lo * side);
        d_gt_reg[1] <= TW'(g_hi * side);
        d_bt_reg[0] <= TW'(b_lo * side_sq);
        d_bt_reg[1] <= TW'(b_hi * side_sq);
        for (int k = 0; k < 4; k++)
        begin
            d_rg_reg[k] <= ltg_pkg::W2_W'(rw[k % 2] * gw[k / 2]);
        end
        d_bw_reg[0] <= bw[0];
        d_bw_reg[1] <= bw[1];
    end

    // corner addresses and full weights
    always_comb
    begin
        for (int c = 0; c < 8; c++)
        begin
            asum[c]  = d_rt_reg[c % 2] + d_gt_reg[(c / 2) % 2] + d_bt_reg[c / 4];
            raddr[c] = asum[c][AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 8; c++)
        begin
            e_w_reg[c] <= ltg_pkg::W3_W'(d_rg_reg[c % 4] * d_bw_reg[c / 4]);
        end
    end

    // write loads at the read stage so requests stay in order
    assign we = d_load_reg;

    for (genvar c = 0; c < 8; c++)
    begin : g_bank
        ltg_ram #(.WIDTH(SUMW), .DEPTH(DEPTH)) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (AW'(d_idx_reg)),
            .wdata (d_sum_reg),
            .raddr (raddr[c]),
            .rdata (rdata[c])
        );
    end

    ltg_reduce u_reduce (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (e_pix_reg),
        .sum          (rdata),
        .wgt          (e_w_reg),
        .result_valid (result_valid),
        .gray_value   (gray_value)
    );

    // a result follows a pixel request by a fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, 9) |->
        (result_valid == $past(start && (operation == ltg_pkg::OP_PIXEL), 9)))
        else $error("result does not match pixel request latency");

    // a table write comes only from an earlier load request
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ($past(start, 4) && ($past(operation, 4) == ltg_pkg::OP_LOAD)))
        else $error("table write without load request");

    // a load and a pixel never share the read stage
    a_stage_excl: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> !d_pix_reg)
        else $error("write and read in one stage");

endmodule

@@ verif/lut3d_trilinear_gray_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut3d_trilinear_gray_checker: prediction and compare for the gray 3D table
// Mirrors every accepted load and lut_side write. Predicts the gray byte of
// each accepted pixel and compares each strobed result with the oldest one.
// ----------------------------------------------------------------------------
module lut3d_trilinear_gray_checker #(
    parameter int MAX_SIDE = 33
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               operation,
    input  logic        [15:0] entry_index,
    input  logic signed [15:0] entry_red,
    input  logic signed [15:0] entry_green,
    input  logic signed [15:0] entry_blue,
    input  logic        [7:0]  pixel_red,
    input  logic        [7:0]  pixel_green,
    input  logic        [7:0]  pixel_blue,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic        [5:0]  cfg_data,
    input  logic               result_valid,
    input  logic        [7:0]  gray_value,
    output int                 fail_count,
    output int                 gray_pending
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam longint TOTAL_ONE3 = longint'(3) << 38;

    // sum of the three colours of each entry
    int          colour_sum [0:DEPTH-1];
    logic [5:0]  side_reg;
    logic [7:0]  gray_expected [$];

    // Work out the gray byte of one pixel from the mirrored table
    function automatic logic [7:0] predict_gray(input logic [7:0] pr, input logic [7:0] pg,
                                                input logic [7:0] pb);
        int unsigned s;
        int unsigned px [3];
        int unsigned lo [3];
        int unsigned hi [3];
        int unsigned fr [3];
        int unsigned prod;
        int unsigned ix [3];
        longint      wt [3];
        longint      total;
        int unsigned addr;
        s = side_reg;
        if (s < 2)
            s = 2;
        if (s > MAX_SIDE)
            s = MAX_SIDE;
        px[0] = pr;
        px[1] = pg;
        px[2] = pb;
        for (int ch = 0; ch < 3; ch++)
        begin
            prod = px[ch] * (s - 1);
            lo[ch] = prod / 255;
            if (lo[ch] > s - 1)
                lo[ch] = s - 1;
            hi[ch] = (lo[ch] + 1 > s - 1) ? s - 1 : lo[ch] + 1;
            fr[ch] = ((prod % 255) * 256) / 255;
        end
        total = 0;
        for (int c = 0; c < 8; c++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                ix[ch] = c[ch] ? hi[ch] : lo[ch];
                wt[ch] = c[ch] ? longint'(fr[ch]) : longint'(256 - fr[ch]);
            end
            addr = ix[0] + ix[1] * s + ix[2] * s * s;
            if (addr < DEPTH)
                total += longint'(colour_sum[addr]) * wt[0] * wt[1] * wt[2];
        end
        if (total <= 0)
            return 8'd0;
        if (total >= TOTAL_ONE3)
            return 8'd255;
        return 8'((total * 255) / TOTAL_ONE3);
    endfunction

    // Track requests, register writes and results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= 6'd33;
            gray_expected.delete();
            fail_count <= 0;
            gray_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                side_reg <= cfg_data;
            if (start && !busy)
            begin
                if (operation == ltg_pkg::OP_LOAD)
                begin
                    if (entry_index < DEPTH)
                        colour_sum[entry_index] = int'(entry_red) + int'(entry_green)
                                                  + int'(entry_blue);
                end
                else
                    gray_expected.push_back(predict_gray(pixel_red, pixel_green, pixel_blue));
            end
            if (result_valid)
            begin
                if (gray_expected.size() == 0)
                begin
                    $error("gray_value: expected none, actual %0d", gray_value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (gray_value !== gray_expected[0])
                    begin
                        $error("gray_value: expected %0d, actual %0d",
                               gray_expected[0], gray_value);
                        fail_count <= fail_count + 1;
                    end
                    void'(gray_expected.pop_front());
                end
            end
            gray_pending <= gray_expected.size();
        end
    end

endmodule

@@ verif/lut3d_trilinear_gray_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut3d_trilinear_gray_core_test: stimulus and verdict for the gray 3D table
// Loads the entries that pixels can reach, then runs directed pixels and
// random phases of loads and pixels over several lut_side settings and idle
// rates.
// ----------------------------------------------------------------------------
module lut3d_trilinear_gray_core_test;

    localparam int MAX_SIDE = 33;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int LIMIT    = 40000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               operation = ltg_pkg::OP_LOAD;
    logic        [15:0] entry_index = '0;
    logic signed [15:0] entry_red = '0;
    logic signed [15:0] entry_green = '0;
    logic signed [15:0] entry_blue = '0;
    logic        [7:0]  pixel_red = '0;
    logic        [7:0]  pixel_green = '0;
    logic        [7:0]  pixel_blue = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic        [5:0]  cfg_data = '0;
    logic               result_valid;
    logic        [7:0]  gray_value;
    int                 fail_count;
    int                 gray_pending;
    int                 cycle_count = 0;
    int                 side_now = 33;

    always #4 clk = ~clk;

    lut3d_trilinear_gray_core #(.MAX_SIDE(MAX_SIDE)) dut (.*);

    lut3d_trilinear_gray_checker #(.MAX_SIDE(MAX_SIDE)) checker_i (.*);

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("[lut3d_trilinear_gray_core] ERROR");
            $finish;
        end
    end

    // Pick an entry colour: full range, extremes or the usual range
    function automatic logic signed [15:0] pick_colour();
        case ($urandom_range(3))
            0: return 16'($urandom());
            1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom_range(18000));
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom());
        endcase
    endfunction

    // Pick an axis byte that only reaches loaded entries under side_now:
    // small cubes are fully loaded, larger ones only near both axis ends
    function automatic logic [7:0] pick_axis_byte();
        int low_max;
        int high_min;
        if (side_now <= 5)
            return pick_byte();
        low_max  = 509 / (side_now - 1);
        high_min = ((side_now - 2) * 255 + side_now - 2) / (side_now - 1);
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(low_max, 0));
        return 8'($urandom_range(255, high_min));
    endfunction

    // Issue one request, with random idle cycles before it
    task automatic send_request(input logic op, input logic [15:0] idx,
                                input logic [7:0] pr, input logic [7:0] pg,
                                input logic [7:0] pb, input int idle_pct);
        @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        operation   <= op;
        entry_index <= idx;
        entry_red   <= pick_colour();
        entry_green <= pick_colour();
        entry_blue  <= pick_colour();
        pixel_red   <= pr;
        pixel_green <= pg;
        pixel_blue  <= pb;
        start       <= 1'b1;
        #1;
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Hold off until every gray byte is back and the pipeline is empty
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (gray_pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_side(input logic [5:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        #1;
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        side_now = (value < 2) ? 2 : (value > MAX_SIDE) ? MAX_SIDE : value;
    endtask

    // Load every entry that a pixel from pick_axis_byte can reach
    task automatic load_region();
        int pts [5];
        int n;
        if (side_now <= 5)
        begin
            n = side_now;
            for (int k = 0; k < 5; k++)
                pts[k] = k;
        end
        else
        begin
            n = 5;
            pts[0] = 0;
            pts[1] = 1;
            pts[2] = 2;
            pts[3] = side_now - 2;
            pts[4] = side_now - 1;
        end
        for (int b = 0; b < n; b++)
            for (int g = 0; g < n; g++)
                for (int r = 0; r < n; r++)
                    send_request(ltg_pkg::OP_LOAD,
                                 16'(pts[r] + pts[g] * side_now + pts[b] * side_now * side_now),
                                 8'd0, 8'd0, 8'd0, 0);
    endtask

    // Random mix of pixels and loads under one setting
    task automatic run_phase(input logic [5:0] side_val, input int idle_pct, input int count);
        int cube;
        logic [15:0] idx;
        drain();
        write_side(side_val);
        load_region();
        cube = side_now * side_now * side_now;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 70)
                send_request(ltg_pkg::OP_PIXEL, 16'($urandom()), pick_axis_byte(),
                             pick_axis_byte(), pick_axis_byte(), idle_pct);
            else
            begin
                case ($urandom_range(9))
                    0: idx = 16'($urandom_range(65535, DEPTH));
                    1: idx = 16'($urandom_range(DEPTH - 1, cube - 1));
                    default: idx = 16'($urandom_range(cube - 1));
                endcase
                send_request(ltg_pkg::OP_LOAD, idx, 8'($urandom()), 8'($urandom()),
                             8'($urandom()), idle_pct);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Load the reachable entries under the reset side
        load_region();
        // Drop loads beyond the store
        send_request(ltg_pkg::OP_LOAD, 16'(DEPTH), 8'd0, 8'd0, 8'd0, 0);
        send_request(ltg_pkg::OP_LOAD, 16'hFFFF, 8'd0, 8'd0, 8'd0, 0);

        // Directed pixels at the axis extremes and edges, reset side
        send_request(ltg_pkg::OP_PIXEL, 16'hFFFF, 8'd0, 8'd0, 8'd0, 0);
        send_request(ltg_pkg::OP_PIXEL, 16'h0000, 8'd255, 8'd255, 8'd255, 0);
        send_request(ltg_pkg::OP_PIXEL, 16'h5A5A, 8'd255, 8'd0, 8'd10, 0);
        send_request(ltg_pkg::OP_PIXEL, 16'hA5A5, 8'd1, 8'd254, 8'd15, 0);
        send_request(ltg_pkg::OP_PIXEL, 16'h0001, 8'd8, 8'd250, 8'd255, 0);
        // Side below range acts as two, above range as the maximum
        drain();
        write_side(6'd0);
        load_region();
        send_request(ltg_pkg::OP_PIXEL, 16'h0, 8'd0, 8'd255, 8'd128, 0);
        send_request(ltg_pkg::OP_PIXEL, 16'h0, 8'd255, 8'd127, 8'd1, 0);
        drain();
        write_side(6'd1);
        send_request(ltg_pkg::OP_PIXEL, 16'h0, 8'd200, 8'd55, 8'd255, 0);
        drain();
        write_side(6'd63);
        send_request(ltg_pkg::OP_PIXEL, 16'h0, 8'd255, 8'd255, 8'd0, 0);
        send_request(ltg_pkg::OP_PIXEL, 16'h0, 8'd3, 8'd250, 8'd254, 0);
        drain();
        write_side(6'd2);
        // Store a load beyond the small cube, then read the cube corners
        send_request(ltg_pkg::OP_LOAD, 16'd9, 8'd0, 8'd0, 8'd0, 0);
        send_request(ltg_pkg::OP_PIXEL, 16'h0, 8'd255, 8'd255, 8'd255, 0);
        send_request(ltg_pkg::OP_PIXEL, 16'h0, 8'd128, 8'd64, 8'd192, 0);

        // Random phases over settings and idle rates
        run_phase(6'd3, 0, 110);
        run_phase(6'd42, 88, 110);
        run_phase(6'd5, 34, 110);
        run_phase(6'd2, 0, 110);
        run_phase(6'd17, 88, 110);
        run_phase(6'd9, 34, 110);

        drain();
        if (fail_count == 0)
            $display("[lut3d_trilinear_gray_core] OK");
        else
            $display("[lut3d_trilinear_gray_core] ERROR");
        $finish;
    end

endmodule
